FILE: rtl/core/drp_pkg.sv
// Shared types and constants for the digitizer record parser.
// Depends on nothing; every other file in rtl/core imports it.
package drp_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned MAX_WORDS = 4096;
  localparam int unsigned HDR_WORDS = 16;

  localparam logic [WORD_W-1:0] MARKER        = 16'hAAAA;
  localparam logic [WORD_W-1:0] BASELINE_INIT = 16'd512;
  localparam logic [LEN_W-1:0]  MAX_LEN       = LEN_W'(MAX_WORDS);
  localparam logic [LEN_W-1:0]  MIN_LEN       = LEN_W'(HDR_WORDS);

  typedef enum logic [2:0] {
    KIND_HEADER       = 3'd0,
    KIND_TRACE        = 3'd1,
    KIND_BAD_MARKER   = 3'd2,
    KIND_LEN_MISMATCH = 3'd3,
    KIND_TOO_SHORT    = 3'd4
  } kind_t;

  // Input tdata, lowest bits last in the list.
  typedef struct packed {
    logic [2:0]        pad;
    logic [LEN_W-1:0]  record_buffer_words;
    logic [WORD_W-1:0] word;
  } in_item_t;

  // Output tdata, lowest bits last in the list.
  typedef struct packed {
    logic        pad;
    logic [15:0] trace_sample;
    logic [63:0] cfd_points;
    logic [47:0] cfd_timestamp;
    logic [1:0]  energy_flags;
    logic [23:0] energy;
    logic [47:0] led_timestamp;
    logic [11:0] module_res;
    logic [3:0]  channel;
    logic [4:0]  board;
  } payload_t;

  localparam int unsigned IN_TDATA_W  = $bits(in_item_t);
  localparam int unsigned OUT_TDATA_W = $bits(payload_t);

  typedef struct packed {
    logic     valid;
    kind_t    kind;
    logic     last;
    payload_t payload;
  } result_t;

endpackage

FILE: rtl/core/drp_engine.sv
// Record framing, marker and length checks, header capture and trace samples.
// Depends on drp_pkg; updates its state on each consumed word.
module drp_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [drp_pkg::WORD_W-1:0] word,
  input  logic [drp_pkg::LEN_W-1:0]  blen,
  input  logic [drp_pkg::WORD_W-1:0] baseline,
  output drp_pkg::result_t           res
);
  import drp_pkg::*;

  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] exp_len_r, exp_len;
  logic             discard_r, discard_nxt;

  logic [4:0]  board_r, board_nxt;
  logic [3:0]  channel_r, channel_nxt;
  logic [11:0] module_r, module_nxt;
  logic [47:0] led_r, led_nxt;
  logic [23:0] energy_r, energy_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [47:0] cfd_r, cfd_nxt;
  logic [47:0] points_r, points_nxt;

  logic             last;
  logic [LEN_W-1:0] decl;

  always_comb begin
    exp_len     = (pos_r == '0) ? blen : exp_len_r;
    last        = ({1'b0, pos_r} + (LEN_W+1)'(1)) >= {1'b0, exp_len};
    decl        = {1'b0, word[10:0], 1'b0} + LEN_W'(2);
    pos_nxt     = last ? '0 : pos_r + LEN_W'(1);
    discard_nxt = last ? 1'b0 : discard_r;
    board_nxt   = board_r;
    channel_nxt = channel_r;
    module_nxt  = module_r;
    led_nxt     = led_r;
    energy_nxt  = energy_r;
    flags_nxt   = flags_r;
    cfd_nxt     = cfd_r;
    points_nxt  = points_r;
    res         = '0;
    res.kind    = KIND_HEADER;

    if (discard_r) begin
      // drop the rest of the record
    end else if (pos_r < LEN_W'(2)) begin
      if (word != MARKER) begin
        res.valid = 1'b1;
        res.kind  = KIND_BAD_MARKER;
      end else if (last) begin
        res.valid = 1'b1;
        res.kind  = KIND_TOO_SHORT;
      end
    end else if (pos_r == LEN_W'(2)) begin
      if (decl != exp_len || decl > MAX_LEN) begin
        res.valid = 1'b1;
        res.kind  = KIND_LEN_MISMATCH;
      end else if (decl < MIN_LEN) begin
        res.valid = 1'b1;
        res.kind  = KIND_TOO_SHORT;
      end else begin
        board_nxt = word[15:11];
      end
    end else if (pos_r < MIN_LEN) begin
      case (pos_r[3:0])
        4'd3: begin
          channel_nxt = word[3:0];
          module_nxt  = word[15:4];
        end
        4'd4:  led_nxt[31:16]    = word;
        4'd5:  led_nxt[15:0]     = word;
        4'd6:  energy_nxt[15:0]  = word;
        4'd7:  led_nxt[47:32]    = word;
        4'd8:  cfd_nxt[15:0]     = word;
        4'd9: begin
          energy_nxt[23:16] = word[7:0];
          flags_nxt         = {word[15], word[8]};
        end
        4'd10: cfd_nxt[47:32]    = word;
        4'd11: cfd_nxt[31:16]    = word;
        4'd12: points_nxt[15:0]  = word;
        4'd13: points_nxt[31:16] = word;
        4'd14: points_nxt[47:32] = word;
        default: ;
      endcase
      if (pos_r[3:0] == 4'd15) begin
        res.valid                 = 1'b1;
        res.kind                  = KIND_HEADER;
        res.last                  = last;
        res.payload.board         = board_r;
        res.payload.channel       = channel_r;
        res.payload.module_res    = module_r;
        res.payload.led_timestamp = led_r;
        res.payload.energy        = energy_r;
        res.payload.energy_flags  = flags_r;
        res.payload.cfd_timestamp = cfd_r;
        res.payload.cfd_points    = {word, points_r};
      end
    end else begin
      res.valid                = 1'b1;
      res.kind                 = KIND_TRACE;
      res.last                 = last;
      res.payload.trace_sample = baseline - word;
    end

    if (res.valid && res.kind != KIND_HEADER && res.kind != KIND_TRACE) begin
      res.last    = 1'b1;
      discard_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      exp_len_r <= '0;
      discard_r <= 1'b0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      exp_len_r <= exp_len;
      discard_r <= discard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      board_r   <= board_nxt;
      channel_r <= channel_nxt;
      module_r  <= module_nxt;
      led_r     <= led_nxt;
      energy_r  <= energy_nxt;
      flags_r   <= flags_nxt;
      cfd_r     <= cfd_nxt;
      points_r  <= points_nxt;
    end
  end

endmodule

FILE: rtl/core/digitizer_record_parser.sv
// Top level of the digitizer record parser: input register, engine, result register.
// Depends on drp_pkg and drp_engine.
//
//   channel | direction | payload                               | sideband
//   in_     | slave     | tdata: word, record_buffer_words      | -
//   out_    | master    | tdata: header fields, trace_sample    | tuser: record_kind, tlast
//   cfg_    | slave     | data: trace_baseline                  | always ready
//
// One word per cycle sustained while the result channel is not stalled; a word's result is
// registered in the result register from the input register through the combinational engine.
// Synchronous active-low reset clears framing state; baseline returns to 512.
// A stalled result holds the input register, which then holds in_tready low.
module digitizer_record_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [drp_pkg::IN_TDATA_W-1:0]  in_tdata,   // word[15:0], record_buffer_words[28:16]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [drp_pkg::OUT_TDATA_W-1:0] out_tdata,  // board, channel, module_res,
                                                      // led_timestamp, energy, energy_flags,
                                                      // cfd_timestamp, cfd_points, trace_sample
  output logic [2:0]                      out_tuser,  // record_kind[2:0]
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drp_pkg::WORD_W-1:0]      cfg_data
);
  import drp_pkg::*;

  logic            in_valid_r;
  in_item_t        in_item_r;
  logic [WORD_W-1:0] baseline_r;
  logic            advance;
  result_t         res;

  logic            out_valid_r;
  kind_t           out_kind_r;
  logic            out_last_r;
  payload_t        out_payload_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r <= BASELINE_INIT;
    end else if (cfg_valid) begin
      baseline_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item_t'(in_tdata);
    end
  end

  drp_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .word     (in_item_r.word),
    .blen     (in_item_r.record_buffer_words),
    .baseline (baseline_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_kind_r    <= res.kind;
      out_last_r    <= res.last;
      out_payload_r <= res.payload;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_payload_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/core/drp_checker.sv
// Port-level checks on the result channel of the digitizer record parser.
// Depends on drp_pkg; bound to digitizer_record_parser at the end of this file.
module drp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [drp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]                      out_tuser,
  input logic                            out_tlast
);
  import drp_pkg::*;

  payload_t pl;
  assign pl = payload_t'(out_tdata);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_BAD_MARKER || out_tuser == KIND_LEN_MISMATCH ||
                   out_tuser == KIND_TOO_SHORT) |-> out_tlast)
    else $error("error result without end of record");

  a_trace_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TRACE |->
      pl.board == '0 && pl.cfd_points == '0 && pl.led_timestamp == '0 && pl.energy == '0)
    else $error("trace result carries header fields");

  a_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_TRACE |-> pl.trace_sample == '0 && pl.pad == 1'b0)
    else $error("non-trace result carries a sample");

endmodule

bind digitizer_record_parser drp_checker u_drp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
